// ===== src/ghacc_pkg.sv =====
// Shared types, constants and GF(2^128) helper functions for the GHASH accumulator.
// No dependencies; every other file in src uses this package by scoped names.

package ghacc_pkg;

  // Reduction constant, GCM reflected order (1 + x + x^2 + x^7)
  localparam logic [7:0] GF_REDUCE = 8'he1;

  // Two-entry queues: count code for "holding two words"
  localparam logic [1:0] Q_CNT_FULL = 2'd2;

  // Item codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Register map, indexed by paddr[3]
  localparam logic REG_KEY_HI = 1'b0;
  localparam logic REG_KEY_LO = 1'b1;

  // Classified word handed from the front end to the back end
  typedef struct packed {
    logic         clear;
    logic [127:0] blk;
  } item_t;

  // Keep the leading n bytes of a big-endian 128-bit block (n above 16 keeps all)
  function automatic logic [127:0] keep_mask(logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < n) begin
        m[127 - 8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  // Z = X * H in GF(2^128), GCM bit order (msb of byte 0 is x^0)
  function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] h);
    logic [127:0] a;
    logic [127:0] b;
    logic [254:0] c;
    logic [134:0] f;
    logic [6:0]   g;
    logic [127:0] d;
    logic [127:0] z;
    // reflect into natural polynomial order
    for (int i = 0; i < 128; i++) begin
      a[i] = x[127 - i];
      b[i] = h[127 - i];
    end
    // carry-less product, each output bit an independent xor tree
    c = '0;
    for (int i = 0; i < 128; i++) begin
      for (int j = 0; j < 128; j++) begin
        c[i + j] = c[i + j] ^ (a[i] & b[j]);
      end
    end
    // first fold of the upper 127 bits
    f = {7'b0, c[127:0]};
    for (int j = 0; j < 8; j++) begin
      if (GF_REDUCE[7 - j]) begin
        f = f ^ ({8'b0, c[254:128]} << j);
      end
    end
    // second fold of the few bits that spilled past degree 127
    g = f[134:128];
    d = f[127:0];
    for (int j = 0; j < 8; j++) begin
      if (GF_REDUCE[7 - j]) begin
        d = d ^ ({121'b0, g} << j);
      end
    end
    for (int i = 0; i < 128; i++) begin
      z[127 - i] = d[i];
    end
    return z;
  endfunction

endpackage

// ===== src/ghacc_cfg.sv =====
// APB-style register file holding the 128-bit hash subkey H.
// Depends on ghacc_pkg for the register map.

module ghacc_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready,
  output logic [127:0] hash_key
);

  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic        wr_en;

  // Access phase of a write; registers are 8 bytes apart
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (wr_en) begin
      if (cfg_paddr[3] == ghacc_pkg::REG_KEY_HI) begin
        key_hi_r <= cfg_pwdata;
      end else begin
        key_lo_r <= cfg_pwdata;
      end
    end
  end

  // Read mux
  assign cfg_prdata = (cfg_paddr[3] == ghacc_pkg::REG_KEY_LO) ? key_lo_r : key_hi_r;
  assign hash_key   = {key_hi_r, key_lo_r};

endmodule

// ===== src/ghacc_front.sv =====
// Front end: accepts input words, masks unused bytes, tags clears, and queues
// them for the back end in a two-entry queue. Depends on ghacc_pkg.

module ghacc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_action,
  input  logic [63:0]         in_block_hi,
  input  logic [63:0]         in_block_lo,
  input  logic [4:0]          in_valid_bytes,
  output logic                item_valid,
  output ghacc_pkg::item_t    item,
  input  logic                item_pop
);

  ghacc_pkg::item_t q_mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             push;
  logic             pop;
  ghacc_pkg::item_t item_in;

  // Classify: tag clears and mask the block; a clear's block is ignored downstream
  always_comb begin
    item_in.clear = (in_action == ghacc_pkg::ACT_CLEAR);
    item_in.blk   = {in_block_hi, in_block_lo} & ghacc_pkg::keep_mask(in_valid_bytes);
  end

  assign in_full    = (cnt_r == ghacc_pkg::Q_CNT_FULL);
  assign push       = in_push && !in_full;
  assign item_valid = (cnt_r != 2'd0);
  assign pop        = item_pop && item_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign item = q_mem_r[rd_ptr_r];

  // Occupancy never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ghacc_pkg::Q_CNT_FULL)
    else $error("front queue count out of range");

  // Pointers differ by exactly the count modulo two
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == cnt_r[0])
    else $error("front queue pointers disagree with count");

  // A word taken while the queue was full leaves room next cycle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && in_full) |=> !in_full)
    else $error("front queue stayed full after a pop");

endmodule

// ===== src/ghacc_back.sv =====
// Back end (uses ghacc_pkg): holds the GHASH accumulator, multiplies in GF(2^128),
// queues digests; one absorb or clear per cycle while the digest queue has room.

module ghacc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [127:0]        hash_key,
  input  logic                item_valid,
  input  ghacc_pkg::item_t    item,
  output logic                item_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [63:0]         out_digest_hi,
  output logic [63:0]         out_digest_lo
);

  logic [127:0] acc_r;
  logic [127:0] acc_nxt;
  logic [127:0] oq_mem_r [2];
  logic         oq_wr_ptr_r;
  logic         oq_rd_ptr_r;
  logic [1:0]   oq_cnt_r;
  logic [1:0]   oq_cnt_nxt;
  logic         take;
  logic         deq;

  // Take a word whenever the digest queue has or is making room
  assign take     = item_valid && ((oq_cnt_r != ghacc_pkg::Q_CNT_FULL) || out_pop);
  assign item_pop = take;
  assign deq      = out_pop && !out_empty;

  // Accumulator update
  always_comb begin
    if (item.clear) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = ghacc_pkg::gf128_mul(acc_r ^ item.blk, hash_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (take) begin
      acc_r <= acc_nxt;
    end
  end

  // Digest queue
  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (take && !deq) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (deq && !take) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_mem_r[oq_wr_ptr_r] <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= 1'b0;
      oq_rd_ptr_r <= 1'b0;
      oq_cnt_r    <= '0;
    end else begin
      if (take) begin
        oq_wr_ptr_r <= !oq_wr_ptr_r;
      end
      if (deq) begin
        oq_rd_ptr_r <= !oq_rd_ptr_r;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  assign out_empty     = (oq_cnt_r == 2'd0);
  assign out_digest_hi = oq_mem_r[oq_rd_ptr_r][127:64];
  assign out_digest_lo = oq_mem_r[oq_rd_ptr_r][63:0];

  // A clear leaves a zero accumulator
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.clear) |=> (acc_r == '0))
    else $error("accumulator not zero after clear");

  // Every word taken shows up as a waiting digest
  a_take_digest: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !out_empty)
    else $error("digest missing after a take");

  // Digest queue never overflows
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= ghacc_pkg::Q_CNT_FULL)
    else $error("digest queue count out of range");

endmodule

// ===== src/ghacc_top.sv =====
// GHASH accumulator top level: joins the key registers, front end and back end, and
// depends on ghacc_pkg, ghacc_cfg, ghacc_front and ghacc_back. The block keeps a
// running GCM GHASH value Y. Each input word either absorbs a 128-bit big-endian
// block, Y = (Y xor X) * H, or clears Y to zero. Bytes past in_valid_bytes are
// zeroed first: a count of zero absorbs an all-zero block, and a count above 16
// keeps the whole block. Every word returns one digest, Y after that word. A word is
// taken at an edge with in_push high and in_full low. The front queue registers it;
// the back end takes it once the digest queue has room, and its digest then waits in
// that queue for the out_ ports, so out_empty is low. The back end runs one word per
// cycle while the digest queue has room. That rate is set by the combinational
// GF(2^128) multiply, which closes the loop on Y. Words can therefore follow back to
// back while the reader keeps popping. If the reader stalls, two digests and two
// input words wait inside the block, and then in_full rises. Load H through the
// cfg_ port (high half at 0x0, low half at 0x8) only while no word is in flight.

module ghash_accumulator_top (
  input  logic        clk,
  input  logic        rst_n,
  // input queue
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic [4:0]  in_valid_bytes,
  // result queue
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_digest_hi,
  output logic [63:0] out_digest_lo,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [127:0]     hash_key;
  logic             item_valid;
  logic             item_pop;
  ghacc_pkg::item_t item;

  ghacc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .hash_key    (hash_key)
  );

  ghacc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_block_hi    (in_block_hi),
    .in_block_lo    (in_block_lo),
    .in_valid_bytes (in_valid_bytes),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop)
  );

  ghacc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .hash_key      (hash_key),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_digest_hi (out_digest_hi),
    .out_digest_lo (out_digest_lo)
  );

endmodule
